[rtl/core/ofst_pkg.sv]
package ofst_pkg;

  // Default number of table slots.
  localparam int unsigned TableEntriesDef = 64;

  // Field widths of one table word.
  localparam int unsigned KeyW   = 64;
  localparam int unsigned OwnerW = 64;
  localparam int unsigned ModesW = 7;
  localparam int unsigned WordW  = 1 + KeyW + OwnerW + ModesW;

  // Bit positions inside the mode field.
  localparam int unsigned MWantRead   = 0;
  localparam int unsigned MWantWrite  = 1;
  localparam int unsigned MWantDelete = 2;
  localparam int unsigned MShareRead  = 3;
  localparam int unsigned MShareWrite = 4;
  localparam int unsigned MShareDel   = 5;
  localparam int unsigned MDelOnClose = 6;

  typedef enum logic [1:0] {
    OpOpen   = 2'd0,
    OpClose  = 2'd1,
    OpSetDoc = 2'd2,
    OpQuery  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StViolation = 2'd1,
    StFull      = 2'd2,
    StNotFound  = 2'd3
  } status_e;

  typedef logic [ModesW-1:0] modes_t;

  // Share conflict between an existing open (old) and a new request (req).
  function automatic logic modes_clash(modes_t old, modes_t req);
    logic acc_old_ok;
    logic acc_req_ok;
    logic doc;
    logic del;
    acc_old_ok = (!old[MWantRead] || req[MShareRead]) &&
                 (!old[MWantWrite] || req[MShareWrite]);
    acc_req_ok = (!req[MWantRead] || old[MShareRead]) &&
                 (!req[MWantWrite] || old[MShareWrite]);
    doc        = old[MDelOnClose] || req[MDelOnClose];
    del        = old[MWantDelete] && !req[MShareDel];
    return !acc_old_ok || !acc_req_ok || doc || del;
  endfunction

endpackage

[rtl/core/open_file_share_table_core.sv]
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | operation, file key, owner, modes
// out     | output    | out_valid_o/out_ready_i | status, file_is_open
//
// After acceptance, each item reads every slot in turn on the single memory read
// port, waits for the last read data, and then passes through the write-back
// state. After reset a clearing pass walks the memory, one slot per cycle,
// before the first item is accepted. A result waits in the output register
// while the next item is taken and scanned; the write-back of that next item
// stalls only while the previous result is held.
module open_file_share_table_core
  import ofst_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TableEntriesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] inode_key_i,
  input  logic [31:0] requester_server_i,
  input  logic [15:0] requester_tree_i,
  input  logic [15:0] file_num_i,
  input  logic        want_read_i,
  input  logic        want_write_i,
  input  logic        want_delete_i,
  input  logic        share_read_i,
  input  logic        share_write_i,
  input  logic        share_delete_i,
  input  logic        delete_on_close_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic        file_is_open_o
);

  localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [AW-1:0] LastAddr = AW'(TABLE_ENTRIES - 1);

  typedef enum logic [1:0] {
    SClear,
    SIdle,
    SScan,
    SWrite
  } state_e;

  typedef logic [WordW-1:0] word_t;

  state_e           state_q;
  logic [AW-1:0]    addr_q;
  logic             last_q;
  logic             rd_vld_q;
  logic [AW-1:0]    rd_idx_q;
  word_t            rd_data_q;

  op_e              op_q;
  logic [KeyW-1:0]  key_q;
  logic [OwnerW-1:0] owner_q;
  modes_t           modes_q;

  logic             key_seen_q;
  logic             clash_q;
  logic             free_found_q;
  logic [AW-1:0]    free_idx_q;
  logic             match_found_q;
  logic [AW-1:0]    match_idx_q;
  modes_t           match_modes_q;

  logic             out_valid_q;
  status_e          status_q;
  logic             is_open_q;

  word_t            mem_q [TABLE_ENTRIES];
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  word_t            mem_wd;
  status_e          wb_status;
  logic             wb_go;

  // Fields of the slot word returned by the memory.
  logic             rd_valid;
  logic [KeyW-1:0]  rd_key;
  logic [OwnerW-1:0] rd_owner;
  modes_t           rd_modes;

  assign rd_valid = rd_data_q[WordW-1];
  assign rd_key   = rd_data_q[KeyW+OwnerW+ModesW-1 -: KeyW];
  assign rd_owner = rd_data_q[OwnerW+ModesW-1 -: OwnerW];
  assign rd_modes = rd_data_q[ModesW-1:0];

  assign in_ready_o = (state_q == SIdle);
  assign wb_go      = (state_q == SWrite) && (!out_valid_q || out_ready_i);

  // Write-back decision and memory write port.
  always_comb begin
    mem_we    = 1'b0;
    mem_wa    = addr_q;
    mem_wd    = '0;
    wb_status = StOk;
    if (state_q == SClear) begin
      mem_we = 1'b1;
    end else begin
      case (op_q)
        OpOpen: begin
          if (clash_q) begin
            wb_status = StViolation;
          end else if (!free_found_q) begin
            wb_status = StFull;
          end else begin
            mem_we = wb_go;
            mem_wa = free_idx_q;
            mem_wd = {1'b1, key_q, owner_q, modes_q};
          end
        end
        OpClose: begin
          if (!match_found_q) begin
            wb_status = StNotFound;
          end else begin
            mem_we = wb_go;
            mem_wa = match_idx_q;
            mem_wd = {1'b0, key_q, owner_q, match_modes_q};
          end
        end
        OpSetDoc: begin
          if (!key_seen_q) begin
            wb_status = StNotFound;
          end else if (match_found_q) begin
            mem_we = wb_go;
            mem_wa = match_idx_q;
            mem_wd = {1'b1, key_q, owner_q, modes_q[MDelOnClose],
                      match_modes_q[ModesW-2:0]};
          end
        end
        default: begin
          wb_status = StOk;
        end
      endcase
    end
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_data_q <= mem_q[addr_q];
  end

  // Sequencer, scan accumulators and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= SClear;
      addr_q        <= '0;
      last_q        <= 1'b0;
      rd_vld_q      <= 1'b0;
      rd_idx_q      <= '0;
      op_q          <= OpOpen;
      key_q         <= '0;
      owner_q       <= '0;
      modes_q       <= '0;
      key_seen_q    <= 1'b0;
      clash_q       <= 1'b0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      match_modes_q <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= StOk;
      is_open_q     <= 1'b0;
    end else begin
      // A taken result clears the output register unless a new one lands.
      if (out_valid_q && out_ready_i && !wb_go) begin
        out_valid_q <= 1'b0;
      end

      // Track which slot the read data belongs to.
      rd_vld_q <= (state_q == SScan) && !last_q;
      rd_idx_q <= addr_q;

      // Fold one slot into the scan result.
      if (rd_vld_q) begin
        if (!rd_valid) begin
          if (!free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= rd_idx_q;
          end
        end else if (rd_key == key_q) begin
          key_seen_q <= 1'b1;
          if (modes_clash(rd_modes, modes_q)) begin
            clash_q <= 1'b1;
          end
          if (!match_found_q && (rd_owner == owner_q)) begin
            match_found_q <= 1'b1;
            match_idx_q   <= rd_idx_q;
            match_modes_q <= rd_modes;
          end
        end
      end

      unique case (state_q)
        SClear: begin
          if (addr_q == LastAddr) begin
            addr_q  <= '0;
            state_q <= SIdle;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        SIdle: begin
          if (in_valid_i) begin
            op_q          <= op_e'(operation_i);
            key_q         <= inode_key_i;
            owner_q       <= {requester_server_i, requester_tree_i, file_num_i};
            modes_q       <= {delete_on_close_i, share_delete_i, share_write_i,
                              share_read_i, want_delete_i, want_write_i,
                              want_read_i};
            key_seen_q    <= 1'b0;
            clash_q       <= 1'b0;
            free_found_q  <= 1'b0;
            match_found_q <= 1'b0;
            addr_q        <= '0;
            last_q        <= 1'b0;
            state_q       <= SScan;
          end
        end
        SScan: begin
          // Issue reads for every slot, then wait for the last read data.
          if (last_q) begin
            state_q <= SWrite;
          end else if (addr_q == LastAddr) begin
            last_q <= 1'b1;
          end else begin
            addr_q <= addr_q + AW'(1);
          end
        end
        SWrite: begin
          if (wb_go) begin
            out_valid_q <= 1'b1;
            status_q    <= wb_status;
            is_open_q   <= (op_q == OpQuery) && key_seen_q;
            addr_q      <= '0;
            state_q     <= SIdle;
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign file_is_open_o = is_open_q;

  // An accepted item always starts a scan.
  a_accept_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == SScan))
    else $error("accepted item did not start a scan");

  // The memory is written only by the clearing pass or the write-back.
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == SClear || state_q == SWrite))
    else $error("memory write outside clear or write-back");

  // A new result appears only out of the write-back state.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == SWrite))
    else $error("result raised outside write-back");

  // Read data is folded in only while a scan runs.
  a_fold_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == SScan))
    else $error("slot data folded outside a scan");

  // A result is never overwritten while it still waits.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !wb_go)
    else $error("write-back while output register is full");

endmodule

[bench/tb_open_file_share_table_core.sv]
module tb_open_file_share_table_core;
  import ofst_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ItemsWanted = 900;
  localparam int unsigned KeyPoolSize = 6;
  localparam int unsigned OwnerPoolSize = 5;
  localparam int unsigned FillCount = TableEntriesDef + 2;
  localparam int unsigned HoldCycles = 600;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ReportLimit = 10;

  // One open-file request as it travels on the input channel.
  typedef struct {
    op_e         op;
    logic [63:0] key;
    logic [31:0] server;
    logic [15:0] tree;
    logic [15:0] fnum;
    modes_t      modes;
  } request_t;

  // One reply of the table.
  typedef struct {
    status_e status;
    logic    is_open;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  operation = '0;
  logic [63:0] inode_key = '0;
  logic [31:0] requester_server = '0;
  logic [15:0] requester_tree = '0;
  logic [15:0] file_num = '0;
  modes_t      req_modes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  status;
  logic        file_is_open;

  // Shadow copy of the open-file table.
  bit          slot_used  [TableEntriesDef];
  logic [63:0] slot_key   [TableEntriesDef];
  logic [63:0] slot_owner [TableEntriesDef];
  modes_t      slot_modes [TableEntriesDef];

  request_t    request_q[$];
  reply_t      reply_q[$];
  logic [63:0] key_pool   [KeyPoolSize];
  logic [63:0] owner_pool [OwnerPoolSize];

  int unsigned items_total = 0;
  int unsigned accepted_cnt = 0;
  int unsigned checked_cnt = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  logic        in_taken = 1'b0;
  logic        hold_off = 1'b0;

  open_file_share_table_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .operation_i       (operation),
    .inode_key_i       (inode_key),
    .requester_server_i(requester_server),
    .requester_tree_i  (requester_tree),
    .file_num_i        (file_num),
    .want_read_i       (req_modes[MWantRead]),
    .want_write_i      (req_modes[MWantWrite]),
    .want_delete_i     (req_modes[MWantDelete]),
    .share_read_i      (req_modes[MShareRead]),
    .share_write_i     (req_modes[MShareWrite]),
    .share_delete_i    (req_modes[MShareDel]),
    .delete_on_close_i (req_modes[MDelOnClose]),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .status_o          (status),
    .file_is_open_o    (file_is_open)
  );

  // Free-running clock, 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // An existing open (held) blocks a new request (asked) when access is not
  // mutually shared, when either carries delete-on-close, or when the held
  // open deletes and the new one does not share delete.
  function automatic bit modes_collide(modes_t held, modes_t asked);
    logic [1:0] held_acc;
    logic [1:0] held_shr;
    logic [1:0] asked_acc;
    logic [1:0] asked_shr;
    held_acc  = {held[MWantWrite], held[MWantRead]};
    held_shr  = {held[MShareWrite], held[MShareRead]};
    asked_acc = {asked[MWantWrite], asked[MWantRead]};
    asked_shr = {asked[MShareWrite], asked[MShareRead]};
    if ((held_acc & ~asked_shr) != 2'b00) return 1'b1;
    if ((asked_acc & ~held_shr) != 2'b00) return 1'b1;
    if (held[MDelOnClose] || asked[MDelOnClose]) return 1'b1;
    return held[MWantDelete] && !asked[MShareDel];
  endfunction

  // Applies one request to the shadow table and returns the reply it earns.
  function automatic reply_t share_table_apply(request_t r);
    reply_t      rsp;
    logic [63:0] owner;
    bit          key_hit;
    bit          conflict;
    int          free_idx;
    int          own_idx;
    owner    = {r.server, r.tree, r.fnum};
    key_hit  = 1'b0;
    conflict = 1'b0;
    free_idx = -1;
    own_idx  = -1;
    rsp.status  = StOk;
    rsp.is_open = 1'b0;
    for (int i = 0; i < TableEntriesDef; i++) begin
      if (!slot_used[i]) begin
        if (free_idx < 0) free_idx = i;
      end else if (slot_key[i] == r.key) begin
        key_hit = 1'b1;
        if (modes_collide(slot_modes[i], r.modes)) conflict = 1'b1;
        if (own_idx < 0 && slot_owner[i] == owner) own_idx = i;
      end
    end
    case (r.op)
      OpOpen: begin
        // A conflict wins over a full table.
        if (conflict) begin
          rsp.status = StViolation;
        end else if (free_idx < 0) begin
          rsp.status = StFull;
        end else begin
          slot_used[free_idx]  = 1'b1;
          slot_key[free_idx]   = r.key;
          slot_owner[free_idx] = owner;
          slot_modes[free_idx] = r.modes;
        end
      end
      OpClose: begin
        if (own_idx < 0) rsp.status = StNotFound;
        else slot_used[own_idx] = 1'b0;
      end
      OpSetDoc: begin
        // A present key without a matching owner still answers ok.
        if (!key_hit) begin
          rsp.status = StNotFound;
        end else if (own_idx >= 0) begin
          slot_modes[own_idx][MDelOnClose] = r.modes[MDelOnClose];
        end
      end
      default: begin
        rsp.is_open = key_hit;
      end
    endcase
    return rsp;
  endfunction

  function automatic modes_t mode_bits(bit wr, bit ww, bit wd, bit sr, bit sw, bit sd,
                                       bit doc);
    modes_t m;
    m = '0;
    m[MWantRead]   = wr;
    m[MWantWrite]  = ww;
    m[MWantDelete] = wd;
    m[MShareRead]  = sr;
    m[MShareWrite] = sw;
    m[MShareDel]   = sd;
    m[MDelOnClose] = doc;
    return m;
  endfunction

  // Random access with sharing mostly granted, so that opens often coexist.
  function automatic modes_t friendly_modes();
    modes_t m;
    m = modes_t'($urandom);
    m[MShareRead]  = ($urandom_range(99) < 85);
    m[MShareWrite] = ($urandom_range(99) < 85);
    m[MShareDel]   = ($urandom_range(99) < 85);
    m[MDelOnClose] = ($urandom_range(99) < 10);
    return m;
  endfunction

  function automatic void queue_request(op_e op, logic [63:0] key, logic [63:0] owner,
                                        modes_t modes);
    request_t r;
    r.op     = op;
    r.key    = key;
    r.server = owner[63:32];
    r.tree   = owner[31:16];
    r.fnum   = owner[15:0];
    r.modes  = modes;
    request_q.push_back(r);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Opens on pooled keys by pooled owners, then queries, option changes and
  // closes on the same key. A few closes are skipped so entries pile up.
  function automatic void queue_session();
    logic [63:0] key;
    logic [63:0] own_a;
    logic [63:0] own_b;
    key   = key_pool[$urandom_range(KeyPoolSize - 1)];
    own_a = owner_pool[$urandom_range(OwnerPoolSize - 1)];
    own_b = owner_pool[$urandom_range(OwnerPoolSize - 1)];
    queue_request(OpOpen, key, own_a, friendly_modes());
    if ($urandom_range(1) == 1) queue_request(OpOpen, key, own_b, friendly_modes());
    if ($urandom_range(2) == 0) queue_request(OpQuery, key, rand64(), modes_t'($urandom));
    if ($urandom_range(1) == 1) begin
      queue_request(OpSetDoc, key, owner_pool[$urandom_range(OwnerPoolSize - 1)],
                    modes_t'($urandom));
    end
    if ($urandom_range(9) != 0) queue_request(OpClose, key, own_a, modes_t'($urandom));
    if ($urandom_range(9) != 0) queue_request(OpClose, key, own_b, modes_t'($urandom));
    if ($urandom_range(1) == 1) queue_request(OpQuery, key, rand64(), modes_t'($urandom));
  endfunction

  // Fills the table with fresh keys until it overflows, tries a conflicting
  // open while full, then closes everything it opened.
  function automatic void queue_fill_burst();
    logic [63:0] fkey [FillCount];
    logic [63:0] fown [FillCount];
    modes_t      m;
    for (int i = 0; i < FillCount; i++) begin
      fkey[i] = rand64();
      fown[i] = rand64();
      m = friendly_modes();
      m[MDelOnClose] = 1'b0;
      queue_request(OpOpen, fkey[i], fown[i], m);
    end
    queue_request(OpOpen, fkey[0], rand64(), mode_bits(1, 1, 1, 1, 1, 1, 1));
    queue_request(OpOpen, rand64(), rand64(), mode_bits(0, 0, 0, 1, 1, 1, 0));
    queue_request(OpQuery, fkey[FillCount - 1], rand64(), modes_t'($urandom));
    for (int i = 0; i < FillCount; i++) begin
      queue_request(OpClose, fkey[i], fown[i], modes_t'($urandom));
    end
  endfunction

  function automatic int unsigned sender_idle_pct();
    if (accepted_cnt < items_total / 3) return 15;
    if (accepted_cnt < 2 * items_total / 3) return 52;
    return 0;
  endfunction

  function automatic int unsigned receiver_idle_pct();
    if (accepted_cnt < items_total / 3) return 52;
    if (accepted_cnt < 2 * items_total / 3) return 15;
    return 0;
  endfunction

  // Input driver: a new item goes out at the falling edge once the previous
  // one was taken, unless the sender idles this cycle.
  always @(negedge clk_i) begin
    request_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (request_q.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
        nxt = request_q.pop_front();
        operation        <= nxt.op;
        inode_key        <= nxt.key;
        requester_server <= nxt.server;
        requester_tree   <= nxt.tree;
        file_num         <= nxt.fnum;
        req_modes        <= nxt.modes;
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Output back-pressure, random per phase, plus the long hold-off.
  always @(negedge clk_i) begin
    out_ready <= !hold_off && ($urandom_range(99) >= receiver_idle_pct());
  end

  // Long receiver hold-off late in the run, while the sender never idles.
  initial begin
    wait (items_total > 0 && accepted_cnt >= items_total * 5 / 6);
    @(negedge clk_i);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(negedge clk_i);
    hold_off <= 1'b0;
  end

  // Monitor: check each returned item, then predict each accepted one.
  always @(posedge clk_i) begin
    request_t acc;
    reply_t   want;
    if (rst_ni && out_valid && out_ready) begin
      if (reply_q.size() == 0) begin
        if (mismatch_cnt < ReportLimit) begin
          $display("unexpected result: status %0d file_is_open %0b", status, file_is_open);
        end
        mismatch_cnt <= mismatch_cnt + 1;
      end else begin
        want = reply_q.pop_front();
        if (status !== want.status || file_is_open !== want.is_open) begin
          if (mismatch_cnt < ReportLimit) begin
            $display("mismatch on result %0d: status exp %0d got %0d, file_is_open exp %0b got %0b",
                     checked_cnt, want.status, status, want.is_open, file_is_open);
          end
          mismatch_cnt <= mismatch_cnt + 1;
        end
      end
      checked_cnt <= checked_cnt + 1;
    end
    if (rst_ni && in_valid && in_ready) begin
      acc.op     = op_e'(operation);
      acc.key    = inode_key;
      acc.server = requester_server;
      acc.tree   = requester_tree;
      acc.fnum   = file_num;
      acc.modes  = req_modes;
      reply_q.push_back(share_table_apply(acc));
      accepted_cnt <= accepted_cnt + 1;
    end
    in_taken <= rst_ni && in_valid && in_ready;
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] k_ones;
    logic [63:0] k_zero;
    logic [63:0] o_ones;
    logic [63:0] o_zero;
    int unsigned fills;
    int unsigned pick;
    k_ones = '1;
    k_zero = '0;
    o_ones = '1;
    o_zero = '0;
    fills  = 0;
    for (int i = 0; i < TableEntriesDef; i++) slot_used[i] = 1'b0;
    for (int i = 0; i < KeyPoolSize; i++) key_pool[i] = rand64();
    for (int i = 0; i < OwnerPoolSize; i++) owner_pool[i] = rand64();

    // Directed part: empty table, sharing rules, option changes, duplicate owners.
    queue_request(OpQuery, k_zero, o_zero, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpClose, k_zero, o_zero, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpSetDoc, k_zero, o_zero, mode_bits(0, 0, 0, 0, 0, 0, 1));
    queue_request(OpOpen, k_ones, o_ones, mode_bits(1, 1, 1, 1, 1, 1, 0));
    queue_request(OpQuery, k_ones, o_zero, mode_bits(1, 1, 1, 1, 1, 1, 1));
    queue_request(OpOpen, k_ones, o_zero, mode_bits(1, 0, 0, 1, 0, 1, 0));
    // Existing read not shared by the new open.
    queue_request(OpOpen, k_ones, o_zero, mode_bits(0, 0, 0, 0, 1, 1, 0));
    // New write access that the existing open does share.
    queue_request(OpOpen, k_ones, o_zero, mode_bits(0, 1, 0, 1, 1, 1, 0));
    // Existing delete access not shared by the new open.
    queue_request(OpOpen, k_ones, o_zero, mode_bits(1, 0, 0, 1, 1, 0, 0));
    queue_request(OpOpen, k_zero, o_zero, mode_bits(0, 0, 1, 0, 0, 0, 0));
    // New delete access is not checked against existing sharing.
    queue_request(OpOpen, k_zero, o_ones, mode_bits(0, 0, 1, 0, 0, 1, 0));
    queue_request(OpOpen, k_zero, o_ones, mode_bits(0, 0, 0, 1, 1, 1, 1));
    // Set-options with the key present but no matching owner.
    queue_request(OpSetDoc, k_ones, 64'h0123_4567_89ab_cdef, mode_bits(0, 0, 0, 0, 0, 0, 1));
    queue_request(OpSetDoc, k_ones, o_ones, mode_bits(0, 0, 0, 0, 0, 0, 1));
    queue_request(OpOpen, k_ones, o_zero, mode_bits(0, 0, 0, 1, 1, 1, 0));
    queue_request(OpSetDoc, k_ones, o_ones, mode_bits(1, 1, 1, 1, 1, 1, 0));
    // Duplicate owner is inserted again; closes remove the lowest match.
    queue_request(OpOpen, k_ones, o_ones, mode_bits(1, 0, 0, 1, 1, 1, 0));
    queue_request(OpClose, k_ones, o_ones, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpQuery, k_ones, o_ones, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpClose, k_ones, o_ones, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpClose, k_ones, o_zero, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpQuery, k_ones, o_zero, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpClose, k_zero, o_zero, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpClose, k_zero, o_ones, mode_bits(0, 0, 0, 0, 0, 0, 0));
    queue_request(OpQuery, k_zero, o_zero, mode_bits(0, 0, 0, 0, 0, 0, 0));

    // Random part: sessions on pooled keys, noise, and two table-filling bursts.
    while (request_q.size() < ItemsWanted) begin
      pick = $urandom_range(99);
      if ((fills == 0 && request_q.size() > 150) || (fills == 1 && request_q.size() > 550)) begin
        queue_fill_burst();
        fills++;
      end else if (pick < 6) begin
        queue_request(op_e'($urandom_range(3)), rand64(), rand64(), modes_t'($urandom));
      end else if (pick < 12) begin
        queue_request(op_e'($urandom_range(3)), key_pool[$urandom_range(KeyPoolSize - 1)],
                      rand64(), modes_t'($urandom));
      end else begin
        queue_session();
      end
    end
    items_total = request_q.size();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_cnt == items_total);
    wait (checked_cnt == items_total);
    repeat (2 * TableEntriesDef + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && reply_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/ofst_pkg.sv
rtl/core/open_file_share_table_core.sv
bench/tb_open_file_share_table_core.sv
